// ----- src/mexp_pkg.sv -----
package mexp_pkg;

	// width of the residue field on the result stream
	localparam int unsigned RESIDUE_WIDTH = 16;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SQR  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// ----- src/modular_exponentiation_16.sv -----
// Modular exponentiation, base^power mod modulus_value, by right-to-left binary
// square-and-multiply over OPERAND_WIDTH-bit unsigned operands. One input transfer
// gives exactly one result transfer. A zero modulus sets the zero_modulus flag in
// m_tuser and returns residue 0 through the ST_DONE state and the output register.
// Otherwise one shared bit-serial modular multiplier does all the work: it takes one
// multiplier bit per cycle (double, conditionally add, reduce twice by compare and
// subtract), and every reduction or product is one pass over all OPERAND_WIDTH
// multiplier bits. An item runs one pass to reduce the base, then for each exponent
// bit from the lowest up a multiply pass if the bit is set and a squaring pass, with
// no squaring after the highest set bit. Exponent zero returns 1 for every nonzero
// modulus, also for a modulus of 1. The block takes one item at a time; s_tready is
// high whenever the sequencer is idle, even while the previous result still waits in
// the output register. residue is the low 16 bits of the result, zero-extended when
// the operand width is narrower.
module modular_exponentiation_16 #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// input stream
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// base_value, power, modulus_value from the lowest bit up, zero padded to bytes
	input  logic [((3 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// result stream
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// residue
	output logic [mexp_pkg::RESIDUE_WIDTH - 1:0]       m_tdata,
	// zero_modulus
	output logic                                       m_tuser
);

	localparam int unsigned W  = OPERAND_WIDTH;
	localparam int unsigned CW = $clog2(OPERAND_WIDTH);

	mexp_pkg::state_t st_q, nxt_st;

	// operand registers
	logic [W - 1:0]  base_q;    // current base power, reduced
	logic [W - 1:0]  exp_q;     // remaining exponent bits
	logic [W - 1:0]  mod_q;
	logic [W - 1:0]  acc_q;     // running result, starts at 1 (0 for a zero modulus)
	logic            zm_q;

	// bit-serial multiplier state
	logic [W - 1:0]  mlt_q;     // multiplier, shifted out msb first
	logic [W - 1:0]  add_q;     // multiplicand, below the modulus
	logic [W - 1:0]  r_q;       // partial remainder
	logic [CW - 1:0] cnt_q;

	// input field split
	logic [W - 1:0]  in_base, in_exp, in_mod;
	logic            s_fire;

	// one step of the multiplier
	logic [W:0]      dbl, dbl_red, sum, sum_red, mod_ext;
	logic [W - 1:0]  res;
	logic            unit_last;

	// next launch of the multiplier
	logic [W - 1:0]  b_cur, e_chk, nxt_mlt, nxt_add;

	// residue formatting
	logic [W + mexp_pkg::RESIDUE_WIDTH - 1:0] acc_ext;

	assign in_base = s_tdata[W - 1:0];
	assign in_exp  = s_tdata[2 * W - 1:W];
	assign in_mod  = s_tdata[3 * W - 1:2 * W];

	assign s_tready = (st_q == mexp_pkg::ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	// r = 2r + bit * addend, kept below the modulus
	assign mod_ext = {1'b0, mod_q};
	assign dbl     = {r_q, 1'b0};
	assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
	assign sum     = dbl_red + (mlt_q[W - 1] ? {1'b0, add_q} : {(W + 1){1'b0}});
	assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
	assign res     = sum_red[W - 1:0];

	assign unit_last = (cnt_q == '0);

	// what the multiplier does after the current pass
	always_comb begin
		b_cur   = (st_q == mexp_pkg::ST_MUL) ? base_q : res;
		e_chk   = (st_q == mexp_pkg::ST_RED) ? exp_q : (exp_q >> 1);
		nxt_st  = mexp_pkg::ST_DONE;
		nxt_mlt = b_cur;
		nxt_add = b_cur;
		priority if (e_chk == '0) begin
			nxt_st = mexp_pkg::ST_DONE;
		end else if (st_q == mexp_pkg::ST_MUL) begin
			nxt_st = mexp_pkg::ST_SQR;
		end else if (e_chk[0]) begin
			// multiply the running result by the fresh base
			nxt_st  = mexp_pkg::ST_MUL;
			nxt_mlt = acc_q;
		end else begin
			nxt_st = mexp_pkg::ST_SQR;
		end
	end

	assign acc_ext = {{mexp_pkg::RESIDUE_WIDTH{1'b0}}, acc_q};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= mexp_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// a finished result loads the output register once it is free
			if ((st_q == mexp_pkg::ST_DONE) && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (st_q)
				mexp_pkg::ST_IDLE: begin
					if (s_fire) begin
						st_q <= (in_mod == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_RED;
					end
				end
				mexp_pkg::ST_RED, mexp_pkg::ST_MUL, mexp_pkg::ST_SQR: begin
					if (unit_last) begin
						st_q <= nxt_st;
					end
				end
				mexp_pkg::ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						st_q <= mexp_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= mexp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			mexp_pkg::ST_IDLE: begin
				if (s_fire) begin
					base_q <= in_base;
					exp_q  <= in_exp;
					mod_q  <= in_mod;
					zm_q   <= (in_mod == '0);
					acc_q  <= (in_mod == '0) ? '0 : W'(1);
					// first pass reduces the base: multiplier bits are the base, addend 1
					mlt_q  <= in_base;
					add_q  <= W'(1);
					r_q    <= '0;
					cnt_q  <= CW'(W - 1);
				end
			end
			mexp_pkg::ST_RED, mexp_pkg::ST_MUL, mexp_pkg::ST_SQR: begin
				if (unit_last) begin
					if (st_q == mexp_pkg::ST_MUL) begin
						acc_q <= res;
					end else begin
						base_q <= res;
					end
					if (st_q == mexp_pkg::ST_SQR) begin
						exp_q <= exp_q >> 1;
					end
					mlt_q <= nxt_mlt;
					add_q <= nxt_add;
					r_q   <= '0;
					cnt_q <= CW'(W - 1);
				end else begin
					mlt_q <= mlt_q << 1;
					r_q   <= res;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			mexp_pkg::ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= acc_ext[mexp_pkg::RESIDUE_WIDTH - 1:0];
					m_tuser <= zm_q;
				end
			end
			default: begin
			end
		endcase
	end

	// partial remainder stays reduced throughout a multiplier pass
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mexp_pkg::ST_RED || st_q == mexp_pkg::ST_MUL || st_q == mexp_pkg::ST_SQR)
		|-> (r_q < mod_q))
		else $error("partial remainder not below modulus");

	// a multiply pass only runs for a set exponent bit
	a_mul_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mexp_pkg::ST_MUL) |-> exp_q[0])
		else $error("multiply pass with clear exponent bit");

	// a nonzero modulus always starts with the base reduction
	a_start_red: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (in_mod != '0)) |=> (st_q == mexp_pkg::ST_RED))
		else $error("base reduction skipped");

	// flagged results carry residue zero
	a_zm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("zero modulus with nonzero residue");

endmodule

// ----- bench/tb_modular_exponentiation_16.sv -----
`timescale 1ns / 1ps

module tb_modular_exponentiation_16;

	localparam int unsigned OPW = 16;
	localparam int unsigned DATA_W = ((3 * OPW + 7) / 8) * 8;
	// cycles with no transfer on either side before the run is declared hung
	localparam int unsigned STALL_LIMIT = 5000;
	// longer than the slowest item, so any late result still shows up
	localparam int unsigned SETTLE_CYCLES = 600;
	localparam int unsigned RANDOM_JOBS = 1000;

	// one operand set waiting to go out; hold_for_idle makes the sender wait
	// until every outstanding result has come back
	typedef struct packed {
		logic [OPW - 1:0] base_value;
		logic [OPW - 1:0] power;
		logic [OPW - 1:0] modulus_value;
		logic             hold_for_idle;
	} operands_t;

	// one result as it should appear on the result stream
	typedef struct packed {
		logic [mexp_pkg::RESIDUE_WIDTH - 1:0] residue;
		logic                                 zero_modulus;
	} residue_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W - 1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [mexp_pkg::RESIDUE_WIDTH - 1:0] m_tdata;
	logic              m_tuser;

	operands_t operand_queue[$];
	residue_t  residues_due[$];

	logic        in_xfer = 1'b0;
	int unsigned operands_taken = 0;
	int unsigned mismatch_count = 0;
	int unsigned stall_cycles = 0;
	logic        calm;

	modular_exponentiation_16 #(
		.OPERAND_WIDTH(OPW)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		// base_value, power, modulus_value from the lowest bit up
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// residue
		.m_tdata (m_tdata),
		// zero_modulus
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// long stretch with no idling on either side
	assign calm = (operands_taken >= 300) && (operands_taken < 500);

	// right-to-left square and multiply, products kept at 32 bits
	function automatic residue_t predict_power_mod(input logic [OPW - 1:0] b,
			input logic [OPW - 1:0] e, input logic [OPW - 1:0] m);
		residue_t         r;
		logic [2 * OPW - 1:0] acc;
		logic [2 * OPW - 1:0] sq;
		r = '0;
		if (m == '0) begin
			// divide by zero case: flag it, residue stays 0
			r.zero_modulus = 1'b1;
			return r;
		end
		acc = 1;
		sq = b % m;
		for (int i = 0; i < OPW; i++) begin
			if (e[i]) begin
				acc = (acc * sq) % m;
			end
			sq = (sq * sq) % m;
		end
		// exponent zero leaves acc at 1, even for a modulus of 1
		r.residue = acc[mexp_pkg::RESIDUE_WIDTH - 1:0];
		return r;
	endfunction

	task automatic add_operands(input logic [OPW - 1:0] b, input logic [OPW - 1:0] e,
			input logic [OPW - 1:0] m, input logic hold);
		operands_t op;
		op.base_value = b;
		op.power = e;
		op.modulus_value = m;
		op.hold_for_idle = hold;
		operand_queue.push_back(op);
	endtask

	// sender: present the next operand set once the current one is taken
	always @(negedge clk) begin : drive_operands
		operands_t op;
		if (arst_n) begin
			if (!s_tvalid || in_xfer) begin
				if (operand_queue.size() > 0
						&& (!operand_queue[0].hold_for_idle || residues_due.size() == 0)
						&& (calm || $urandom_range(99) >= 8)) begin
					op = operand_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {op.modulus_value, op.power, op.base_value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// predict on each input transfer, check on each result transfer
	always @(posedge clk) begin : track_results
		residue_t want;
		in_xfer <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				operands_taken <= operands_taken + 1;
				residues_due.push_back(predict_power_mod(s_tdata[OPW - 1:0],
					s_tdata[2 * OPW - 1:OPW], s_tdata[3 * OPW - 1:2 * OPW]));
			end
			if (m_tvalid && m_tready) begin
				if (residues_due.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					$display("%0t: expected none, actual residue %h zero_modulus %b",
						$time, m_tdata, m_tuser);
				end else begin
					want = residues_due.pop_front();
					if (m_tdata !== want.residue || m_tuser !== want.zero_modulus) begin
						mismatch_count <= mismatch_count + 1;
						$display("%0t: expected residue %h flag %b, actual residue %h flag %b",
							$time, want.residue, want.zero_modulus, m_tdata, m_tuser);
					end
				end
			end
		end
	end

	// hang detection: any transfer restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[modular_exponentiation_16] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [OPW - 1:0] b;
		logic [OPW - 1:0] e;
		logic [OPW - 1:0] m;
		int unsigned      pick;

		// directed: field extremes and the special cases
		add_operands(16'd0, 16'd0, 16'd0, 1'b0);           // zero modulus, all zero
		add_operands(16'hffff, 16'hffff, 16'd0, 1'b0);     // zero modulus, full inputs
		add_operands(16'd12345, 16'd0, 16'd1, 1'b0);       // zero exponent, modulus one
		add_operands(16'd0, 16'd0, 16'd1, 1'b0);
		add_operands(16'd0, 16'd0, 16'd7, 1'b0);           // zero to the zero
		add_operands(16'hffff, 16'd0, 16'hffff, 1'b0);     // zero exponent, top modulus
		add_operands(16'd0, 16'd5, 16'd13, 1'b0);          // zero base
		add_operands(16'hffff, 16'hffff, 16'hffff, 1'b0);  // base equal to modulus
		add_operands(16'hfffe, 16'hffff, 16'hffff, 1'b0);  // all exponent bits set
		add_operands(16'd2, 16'h8000, 16'hfffb, 1'b0);     // only the top exponent bit
		add_operands(16'd3, 16'd1, 16'd2, 1'b0);
		add_operands(16'd7, 16'd1, 16'd65521, 1'b0);       // exponent one
		add_operands(16'd100, 16'd3, 16'd7, 1'b0);         // base above modulus
		add_operands(16'd21, 16'd9, 16'd7, 1'b0);          // base a multiple of modulus
		add_operands(16'hffff, 16'hffff, 16'd1, 1'b0);     // modulus one, nonzero exponent
		add_operands(16'h5555, 16'haaaa, 16'h8001, 1'b0);
		add_operands(16'haaaa, 16'h5555, 16'h7fff, 1'b0);
		add_operands(16'd2, 16'd15, 16'd65535, 1'b0);
		add_operands(16'd65534, 16'd2, 16'd65535, 1'b0);   // minus one squared

		// random part, with a drain before it starts
		for (int n = 0; n < RANDOM_JOBS; n++) begin
			pick = $urandom_range(99);
			if (pick < 5) m = '0;
			else if (pick < 10) m = 16'd1;
			else if (pick < 25) m = 16'($urandom_range(2, 255));
			else if (pick < 35) m = 16'($urandom_range(65000, 65535));
			else m = 16'($urandom);

			pick = $urandom_range(99);
			if (pick < 8) e = '0;
			else if (pick < 18) e = 16'($urandom_range(1, 15));
			else if (pick < 35) e = 16'($urandom_range(16, 255));
			else if (pick < 40) e = 16'hffff;
			else e = 16'($urandom);

			pick = $urandom_range(99);
			if (pick < 5) b = '0;
			else if (pick < 10) b = 16'd1;
			else if (pick < 15) b = 16'hffff;
			else if (pick < 25) b = 16'(m * $urandom_range(1, 40));
			else b = 16'($urandom);

			add_operands(b, e, m, (n == 0) || ($urandom_range(99) == 0));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every operand set to go out and every result to come back
		do @(posedge clk);
		while (operand_queue.size() != 0 || s_tvalid || residues_due.size() != 0);

		// any result arriving now is unexpected
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && residues_due.size() == 0) begin
			$display("[modular_exponentiation_16] OK");
		end else begin
			$display("[modular_exponentiation_16] ERROR");
		end
		$finish;
	end

endmodule

// ----- modular_exponentiation_16.f -----
src/mexp_pkg.sv
src/modular_exponentiation_16.sv
bench/tb_modular_exponentiation_16.sv
